// ===== hdl/row_projection_shift_estimator_macros.svh =====
// Assertion macros used by the port-level checker of the shift estimator.
`ifndef ROW_PROJECTION_SHIFT_ESTIMATOR_MACROS_SVH
`define ROW_PROJECTION_SHIFT_ESTIMATOR_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define RPSE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define RPSE_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rpse_pkg.sv =====
// Types and constants shared by the row projection shift estimator.
package rpse_pkg;

  localparam int SIG_W        = 18;
  localparam int LUMA_W       = 8;
  localparam int NUM_W        = 18;
  localparam int W_RED        = 299;
  localparam int W_GREEN      = 587;
  localparam int W_BLUE       = 114;
  // luma = floor(num / 1000) = (num * ceil(2^28 / 1000)) >> 28, exact for num < 2^18
  localparam int LUMA_MUL     = 268436;
  localparam int LUMA_MUL_W   = 19;
  localparam int LUMA_SHIFT   = 28;
  localparam int LUMA_PROD_W  = NUM_W + LUMA_MUL_W;

  localparam int RANGE_W      = 10;
  localparam int SHIFT_W      = 11;
  localparam int SUM_OUT_W    = 28;
  localparam int ROWS_OUT_W   = 11;
  localparam int PDATA_W      = 32;
  localparam int PADDR_W      = 3;
  localparam int REG_IDX_W    = 1;

  localparam logic [SIG_W-1:0]      SIG_MAX      = '1;
  localparam logic [SUM_OUT_W-1:0]  SUM_OUT_MAX  = '1;
  localparam logic [ROWS_OUT_W-1:0] ROWS_OUT_MAX = '1;
  localparam logic [RANGE_W-1:0]    RANGE_RESET  = 10'd160;

  localparam logic [REG_IDX_W-1:0] REG_SEARCH_RANGE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_MUL_A,
    ST_MUL_B,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic ref_we;
    logic smp_we;
  } row_wr_t;

endpackage

// ===== hdl/row_projection_shift_estimator.sv =====
// A pixel passes a 3-stage luma and row pipeline; one pixel per cycle is taken while pix_stall is low.
// After a sample frame's last pixel the input stalls for the shift search: each
// shift with overlapping rows is set up, scanned, multiplied and compared; a shift with none is only set up.
// The single read port of each row memory sets the one-row-per-cycle scan rate.
// Once the last shift is scored, the result registers load as soon as the output is not stalled.
// Reset clears control, row counters, frame heights and sets search_range to 160;
// the row memories are not cleared.
module row_projection_shift_estimator #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rpse_pkg::PADDR_W-1:0]          paddr,
  input  logic [rpse_pkg::PDATA_W-1:0]          pwdata,
  output logic [rpse_pkg::PDATA_W-1:0]          prdata,
  output logic                                  pready,
  input  logic                                  pix_valid,
  output logic                                  pix_stall,
  input  logic                                  func,
  input  logic [7:0]                            red,
  input  logic [7:0]                            green,
  input  logic [7:0]                            blue,
  input  logic                                  end_of_row,
  input  logic                                  end_of_frame,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic signed [rpse_pkg::SHIFT_W-1:0]   best_shift,
  output logic [rpse_pkg::SUM_OUT_W-1:0]        best_sum,
  output logic [rpse_pkg::ROWS_OUT_W-1:0]       best_rows
);

  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);

  logic [rpse_pkg::RANGE_W-1:0]   search_range;
  logic [rpse_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           cfg_wr;
  rpse_pkg::row_wr_t              wr;
  logic [AW-1:0]                  wr_addr;
  logic [rpse_pkg::SIG_W-1:0]     wr_data;
  logic                           start;
  logic [CW-1:0]                  ref_h;
  logic [CW-1:0]                  smp_h;
  logic [AW-1:0]                  ref_addr;
  logic [AW-1:0]                  smp_addr;
  logic [rpse_pkg::SIG_W-1:0]     ref_q;
  logic [rpse_pkg::SIG_W-1:0]     smp_q;
  logic                           busy;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rpse_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_range <= rpse_pkg::RANGE_RESET;
    end else if (cfg_wr && reg_idx == rpse_pkg::REG_SEARCH_RANGE) begin
      search_range <= pwdata[rpse_pkg::RANGE_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      rpse_pkg::REG_SEARCH_RANGE: prdata = rpse_pkg::PDATA_W'(search_range);
      default:                    prdata = '0;
    endcase
  end

  rpse_front #(
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .pix_valid   (pix_valid),
    .pix_stall   (pix_stall),
    .func        (func),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .end_of_row  (end_of_row),
    .end_of_frame(end_of_frame),
    .search_busy (busy),
    .wr          (wr),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .start       (start),
    .ref_h       (ref_h),
    .smp_h       (smp_h)
  );

  rpse_ram #(
    .WIDTH(rpse_pkg::SIG_W),
    .DEPTH(MAX_ROWS)
  ) u_ref_ram (
    .clk  (clk),
    .we   (wr.ref_we),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(ref_addr),
    .rdata(ref_q)
  );

  rpse_ram #(
    .WIDTH(rpse_pkg::SIG_W),
    .DEPTH(MAX_ROWS)
  ) u_smp_ram (
    .clk  (clk),
    .we   (wr.smp_we),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(smp_addr),
    .rdata(smp_q)
  );

  rpse_search #(
    .MAX_ROWS(MAX_ROWS)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .ref_h       (ref_h),
    .smp_h       (smp_h),
    .search_range(search_range),
    .ref_addr    (ref_addr),
    .smp_addr    (smp_addr),
    .ref_q       (ref_q),
    .smp_q       (smp_q),
    .busy        (busy),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .best_shift  (best_shift),
    .best_sum    (best_sum),
    .best_rows   (best_rows)
  );

endmodule

// ===== hdl/rpse_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rpse_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rpse_front.sv =====
// Pixel path: luma pipeline, row signature accumulation and row store writes.
module rpse_front #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pix_valid,
  output logic                              pix_stall,
  input  logic                              func,
  input  logic [7:0]                        red,
  input  logic [7:0]                        green,
  input  logic [7:0]                        blue,
  input  logic                              end_of_row,
  input  logic                              end_of_frame,
  input  logic                              search_busy,
  output rpse_pkg::row_wr_t                 wr,
  output logic [$clog2(MAX_ROWS)-1:0]       wr_addr,
  output logic [rpse_pkg::SIG_W-1:0]        wr_data,
  output logic                              start,
  output logic [$clog2(MAX_ROWS+1)-1:0]     ref_h,
  output logic [$clog2(MAX_ROWS+1)-1:0]     smp_h
);

  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int NW = rpse_pkg::NUM_W;
  localparam int PW = rpse_pkg::LUMA_PROD_W;

  logic                           accept;
  logic [NW-1:0]                  num_next;
  logic                           a_v;
  logic [NW-1:0]                  a_num;
  logic                           a_func;
  logic                           a_eor;
  logic                           a_eof;
  logic [PW-1:0]                  prod;
  logic                           b_v;
  logic [rpse_pkg::LUMA_W-1:0]    b_luma;
  logic                           b_func;
  logic                           b_eor;
  logic                           b_eof;
  logic [rpse_pkg::SIG_W-1:0]     acc;
  logic [rpse_pkg::SIG_W:0]       acc_sum;
  logic [rpse_pkg::SIG_W-1:0]     acc_sat;
  logic [CW-1:0]                  row_cnt;
  logic [CW-1:0]                  cnt_after;
  logic                           row_end;
  logic                           room;

  // hold input while a sample frame end is in flight or the search runs
  assign pix_stall = search_busy | start | (a_v & a_func & a_eof) | (b_v & b_func & b_eof);
  assign accept    = pix_valid & ~pix_stall;

  assign num_next = NW'(red) * NW'(rpse_pkg::W_RED)
                  + NW'(green) * NW'(rpse_pkg::W_GREEN)
                  + NW'(blue) * NW'(rpse_pkg::W_BLUE);

  assign prod = PW'(a_num) * PW'(rpse_pkg::LUMA_MUL);

  assign acc_sum   = {1'b0, acc} + (rpse_pkg::SIG_W + 1)'(b_luma);
  assign acc_sat   = acc_sum[rpse_pkg::SIG_W] ? rpse_pkg::SIG_MAX
                                              : acc_sum[rpse_pkg::SIG_W-1:0];
  assign row_end   = b_eor | b_eof;
  assign room      = row_cnt < CW'(MAX_ROWS);
  assign cnt_after = (row_end && room) ? row_cnt + CW'(1) : row_cnt;

  assign wr.ref_we = b_v & row_end & room & ~b_func;
  assign wr.smp_we = b_v & row_end & room & b_func;
  assign wr_addr   = row_cnt[AW-1:0];
  assign wr_data   = acc_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v     <= 1'b0;
      b_v     <= 1'b0;
      acc     <= '0;
      row_cnt <= '0;
      ref_h   <= '0;
      smp_h   <= '0;
      start   <= 1'b0;
    end else begin
      a_v    <= accept;
      a_num  <= num_next;
      a_func <= func;
      a_eor  <= end_of_row;
      a_eof  <= end_of_frame;

      b_v    <= a_v;
      b_luma <= prod[rpse_pkg::LUMA_SHIFT +: rpse_pkg::LUMA_W];
      b_func <= a_func;
      b_eor  <= a_eor;
      b_eof  <= a_eof;

      start <= b_v & b_eof & b_func;
      if (b_v) begin
        acc     <= row_end ? '0 : acc_sat;
        row_cnt <= b_eof ? '0 : cnt_after;
        if (b_eof && !b_func) begin
          ref_h <= cnt_after;
        end
        if (b_eof && b_func) begin
          smp_h <= cnt_after;
        end
      end
    end
  end

endmodule

// ===== hdl/rpse_search.sv =====
// Shift search sequencer: one difference accumulator and one shared multiplier.
module rpse_search #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic [$clog2(MAX_ROWS+1)-1:0]            ref_h,
  input  logic [$clog2(MAX_ROWS+1)-1:0]            smp_h,
  input  logic [rpse_pkg::RANGE_W-1:0]             search_range,
  output logic [$clog2(MAX_ROWS)-1:0]              ref_addr,
  output logic [$clog2(MAX_ROWS)-1:0]              smp_addr,
  input  logic [rpse_pkg::SIG_W-1:0]               ref_q,
  input  logic [rpse_pkg::SIG_W-1:0]               smp_q,
  output logic                                     busy,
  output logic                                     res_valid,
  input  logic                                     res_stall,
  output logic signed [rpse_pkg::SHIFT_W-1:0]      best_shift,
  output logic [rpse_pkg::SUM_OUT_W-1:0]           best_sum,
  output logic [rpse_pkg::ROWS_OUT_W-1:0]          best_rows
);

  localparam int AW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_ROWS + 1);
  localparam int SUM_W  = rpse_pkg::SIG_W + AW;
  localparam int SW     = ((CW > rpse_pkg::SHIFT_W) ? CW : rpse_pkg::SHIFT_W) + 2;
  localparam int PW     = SUM_W + CW;
  localparam int SUMX_W = (SUM_W > rpse_pkg::SUM_OUT_W) ? SUM_W : rpse_pkg::SUM_OUT_W;
  localparam int ROWX_W = (CW > rpse_pkg::ROWS_OUT_W) ? CW : rpse_pkg::ROWS_OUT_W;
  localparam logic signed [SW-1:0] ONE_S = SW'(1);

  rpse_pkg::state_t state, state_next;

  logic signed [SW-1:0]        s;
  logic signed [SW-1:0]        y;
  logic signed [SW-1:0]        y_end;
  logic signed [SW-1:0]        ys;
  logic signed [SW-1:0]        range_s;
  logic signed [SW-1:0]        ref_hs;
  logic signed [SW-1:0]        smp_hs;
  logic signed [SW-1:0]        lo;
  logic signed [SW-1:0]        hi;
  logic signed [SW-1:0]        hi_smp;
  logic                        overlap;
  logic                        scan_more;
  logic                        last_shift;
  logic [CW-1:0]               n;
  logic [SUM_W-1:0]            sum;
  logic                        rd_v;
  logic [rpse_pkg::SIG_W-1:0]  absd;
  logic [SUM_W-1:0]            mul_x;
  logic [CW-1:0]               mul_y;
  logic [PW-1:0]               mul_p;
  logic [PW-1:0]               prod_a;
  logic [PW-1:0]               prod_b;
  logic                        found;
  logic signed [SW-1:0]        best_s;
  logic [SUM_W-1:0]            best_sum_r;
  logic [CW-1:0]               best_n;
  logic [SUMX_W-1:0]           sum_x;
  logic [ROWX_W-1:0]           rows_x;
  logic                        load;

  assign range_s    = $signed(SW'(search_range));
  assign ref_hs     = $signed(SW'(ref_h));
  assign smp_hs     = $signed(SW'(smp_h));
  // overlap of reference rows [0, ref_h) with sample rows shifted by s
  assign lo         = s[SW-1] ? -s : '0;
  assign hi_smp     = smp_hs - s;
  assign hi         = (ref_hs < hi_smp) ? ref_hs : hi_smp;
  assign overlap    = hi > lo;
  assign scan_more  = y < y_end;
  assign last_shift = s == range_s;

  assign ys       = y + s;
  assign ref_addr = y[AW-1:0];
  assign smp_addr = ys[AW-1:0];
  assign absd     = (ref_q >= smp_q) ? ref_q - smp_q : smp_q - ref_q;

  // one multiplier serves both sides of the cross-multiplied mean compare
  assign mul_x = (state == rpse_pkg::ST_MUL_A) ? sum : best_sum_r;
  assign mul_y = (state == rpse_pkg::ST_MUL_A) ? best_n : n;
  assign mul_p = PW'(mul_x) * PW'(mul_y);

  assign sum_x  = SUMX_W'(best_sum_r);
  assign rows_x = ROWX_W'(best_n);
  assign busy   = state != rpse_pkg::ST_IDLE;
  assign load   = (state == rpse_pkg::ST_DONE) && (!res_valid || !res_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      rpse_pkg::ST_IDLE: begin
        if (start) state_next = rpse_pkg::ST_SETUP;
      end
      rpse_pkg::ST_SETUP: begin
        if (overlap) begin
          state_next = rpse_pkg::ST_SCAN;
        end else if (last_shift) begin
          state_next = rpse_pkg::ST_DONE;
        end
      end
      rpse_pkg::ST_SCAN: begin
        if (!scan_more) state_next = rpse_pkg::ST_MUL_A;
      end
      rpse_pkg::ST_MUL_A: state_next = rpse_pkg::ST_MUL_B;
      rpse_pkg::ST_MUL_B: state_next = rpse_pkg::ST_CMP;
      rpse_pkg::ST_CMP: begin
        state_next = last_shift ? rpse_pkg::ST_DONE : rpse_pkg::ST_SETUP;
      end
      rpse_pkg::ST_DONE: begin
        if (load) state_next = rpse_pkg::ST_IDLE;
      end
      default: state_next = rpse_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v      <= 1'b0;
      found     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        rpse_pkg::ST_IDLE: begin
          if (start) begin
            s          <= -range_s;
            found      <= 1'b0;
            best_s     <= '0;
            best_sum_r <= '0;
            best_n     <= '0;
          end
        end
        rpse_pkg::ST_SETUP: begin
          y     <= lo;
          y_end <= hi;
          n     <= CW'(hi - lo);
          sum   <= '0;
          rd_v  <= 1'b0;
          if (!overlap && !last_shift) begin
            s <= s + ONE_S;
          end
        end
        rpse_pkg::ST_SCAN: begin
          // read data is registered and lands in the cycle after its address
          rd_v <= scan_more;
          if (scan_more) begin
            y <= y + ONE_S;
          end
          if (rd_v) begin
            sum <= sum + SUM_W'(absd);
          end
        end
        rpse_pkg::ST_MUL_A: prod_a <= mul_p;
        rpse_pkg::ST_MUL_B: prod_b <= mul_p;
        rpse_pkg::ST_CMP: begin
          // strict less-than keeps the earliest, most negative shift on ties
          if (!found || prod_a < prod_b) begin
            found      <= 1'b1;
            best_s     <= s;
            best_sum_r <= sum;
            best_n     <= n;
          end
          if (!last_shift) begin
            s <= s + ONE_S;
          end
        end
        default: begin
        end
      endcase

      if (load) begin
        res_valid  <= 1'b1;
        best_shift <= $signed(best_s[rpse_pkg::SHIFT_W-1:0]);
        best_sum   <= (sum_x > SUMX_W'(rpse_pkg::SUM_OUT_MAX))
                      ? rpse_pkg::SUM_OUT_MAX : sum_x[rpse_pkg::SUM_OUT_W-1:0];
        best_rows  <= (rows_x > ROWX_W'(rpse_pkg::ROWS_OUT_MAX))
                      ? rpse_pkg::ROWS_OUT_MAX : rows_x[rpse_pkg::ROWS_OUT_W-1:0];
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/rpse_checker.sv =====
// Port-level checks for the shift estimator and their binding to the top level.
`include "row_projection_shift_estimator_macros.svh"

module rpse_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                pix_valid,
  input logic                                pix_stall,
  input logic                                func,
  input logic                                end_of_frame,
  input logic                                res_valid,
  input logic                                res_stall,
  input logic signed [rpse_pkg::SHIFT_W-1:0] best_shift,
  input logic [rpse_pkg::SUM_OUT_W-1:0]      best_sum,
  input logic [rpse_pkg::ROWS_OUT_W-1:0]     best_rows
);

  `RPSE_ASSERT_RST(a_reset_quiet, rst |=> (!res_valid && !pix_stall), "not idle after reset")

  `RPSE_ASSERT(a_sample_end_stalls, (pix_valid && !pix_stall && func && end_of_frame) |=> pix_stall, "input not stalled after sample frame end")

  `RPSE_ASSERT(a_no_overlap_zero, (res_valid && best_rows == '0) |-> (best_sum == '0 && best_shift == '0), "empty result carries nonzero fields")

  `RPSE_ASSERT(a_result_holds, (res_valid && res_stall) |=> (res_valid && $stable(best_shift) && $stable(best_sum) && $stable(best_rows)), "stalled result changed")

endmodule

bind row_projection_shift_estimator rpse_checker u_rpse_checker (
  .clk         (clk),
  .rst         (rst),
  .pix_valid   (pix_valid),
  .pix_stall   (pix_stall),
  .func        (func),
  .end_of_frame(end_of_frame),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .best_shift  (best_shift),
  .best_sum    (best_sum),
  .best_rows   (best_rows)
);

// ===== tb/shift_estimate_checker.sv =====
// Checker for the row projection shift estimator: predicts shift results and compares them.
module shift_estimate_checker #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rpse_pkg::PADDR_W-1:0]        paddr,
  input  logic [rpse_pkg::PDATA_W-1:0]        pwdata,
  input  logic [rpse_pkg::PDATA_W-1:0]        prdata,
  input  logic                                pready,
  input  logic                                pix_valid,
  input  logic                                pix_stall,
  input  logic                                func,
  input  logic [7:0]                          red,
  input  logic [7:0]                          green,
  input  logic [7:0]                          blue,
  input  logic                                end_of_row,
  input  logic                                end_of_frame,
  input  logic                                res_valid,
  input  logic                                res_stall,
  input  logic signed [rpse_pkg::SHIFT_W-1:0] best_shift,
  input  logic [rpse_pkg::SUM_OUT_W-1:0]      best_sum,
  input  logic [rpse_pkg::ROWS_OUT_W-1:0]     best_rows,
  output int                                  fails,
  output int                                  pending
);
  import rpse_pkg::*;

  localparam int LUMA_DIV = 1000;
  localparam logic [PADDR_W-1:0] ADDR_SEARCH_RANGE = PADDR_W'(4 * int'(REG_SEARCH_RANGE));

  typedef struct packed {
    logic signed [SHIFT_W-1:0] shift;
    logic [SUM_OUT_W-1:0]      sum;
    logic [ROWS_OUT_W-1:0]     rows;
  } shift_result_t;

  logic [SIG_W-1:0]   ref_sig [MAX_ROWS];
  logic [SIG_W-1:0]   smp_sig [MAX_ROWS];
  int                 row_acc;
  int                 row_cnt;
  int                 ref_height;
  logic [RANGE_W-1:0] search_range;
  shift_result_t      expected_shifts[$];
  int                 mismatch_count = 0;

  function automatic int pixel_luma(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
    return (W_RED * int'(r) + W_GREEN * int'(g) + W_BLUE * int'(b)) / LUMA_DIV;
  endfunction

  function automatic shift_result_t score_shifts();
    int            span, s, y, y_lo, y_hi, diff, best_s;
    longint        total, n, best_total, best_n;
    bit            found;
    shift_result_t res;
    span = int'(search_range);
    found = 1'b0;
    best_s = 0;
    best_total = 0;
    best_n = 0;
    for (s = -span; s <= span; s++) begin
      y_lo = (s < 0) ? -s : 0;
      y_hi = (row_cnt - s < ref_height) ? row_cnt - s : ref_height;
      if (y_hi > y_lo) begin
        total = 0;
        for (y = y_lo; y < y_hi; y++) begin
          diff = int'(ref_sig[y]) - int'(smp_sig[y + s]);
          total += (diff < 0) ? -diff : diff;
        end
        n = y_hi - y_lo;
        // cross-multiplied mean compare; a tie keeps the more negative shift
        if (!found || total * best_n < best_total * n) begin
          found = 1'b1;
          best_s = s;
          best_total = total;
          best_n = n;
        end
      end
    end
    if (best_total > longint'(SUM_OUT_MAX)) best_total = longint'(SUM_OUT_MAX);
    if (best_n > longint'(ROWS_OUT_MAX)) best_n = longint'(ROWS_OUT_MAX);
    res.shift = SHIFT_W'(best_s);
    res.sum = SUM_OUT_W'(best_total);
    res.rows = ROWS_OUT_W'(best_n);
    return res;
  endfunction

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    shift_result_t want;
    if (rst) begin
      row_acc = 0;
      row_cnt = 0;
      ref_height = 0;
      search_range = RANGE_RESET;
      expected_shifts.delete();
    end else begin
      if (psel && penable && pready && paddr == ADDR_SEARCH_RANGE) begin
        if (pwrite) begin
          search_range = pwdata[RANGE_W-1:0];
        end else if (prdata !== PDATA_W'(search_range)) begin
          note_mismatch("search_range readback", longint'(search_range), longint'(prdata));
        end
      end
      // check results before this cycle's pixel can queue a new expectation
      if (res_valid && !res_stall) begin
        if (expected_shifts.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result transaction: shift %0d sum %0d rows %0d",
                     best_shift, best_sum, best_rows);
          end
        end else begin
          want = expected_shifts.pop_front();
          if (best_shift !== want.shift) begin
            note_mismatch("best_shift", longint'(want.shift), longint'(best_shift));
          end
          if (best_sum !== want.sum) begin
            note_mismatch("best_sum", longint'(want.sum), longint'(best_sum));
          end
          if (best_rows !== want.rows) begin
            note_mismatch("best_rows", longint'(want.rows), longint'(best_rows));
          end
        end
      end
      if (pix_valid && !pix_stall) begin
        row_acc += pixel_luma(red, green, blue);
        if (row_acc > int'(SIG_MAX)) row_acc = int'(SIG_MAX);
        if (end_of_row || end_of_frame) begin
          // rows past the store depth are dropped
          if (row_cnt < MAX_ROWS) begin
            if (func) smp_sig[row_cnt] = SIG_W'(row_acc);
            else ref_sig[row_cnt] = SIG_W'(row_acc);
            row_cnt++;
          end
          row_acc = 0;
        end
        if (end_of_frame) begin
          if (func) expected_shifts.push_back(score_shifts());
          else ref_height = row_cnt;
          row_cnt = 0;
        end
      end
    end
    fails <= mismatch_count;
    pending <= expected_shifts.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the shift estimator testbench: clock, reset, pixel and config stimulus, verdict.
module tb_top;
  import rpse_pkg::*;

  localparam int WATCHDOG_LIMIT = 30000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 600;
  localparam int ROW_STORE      = 1024;
  localparam int PHASE_PIXELS   = 250;
  localparam logic [PADDR_W-1:0] ADDR_SEARCH_RANGE = PADDR_W'(4 * int'(REG_SEARCH_RANGE));

  logic                      clk;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [PDATA_W-1:0]        pwdata;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;
  logic                      pix_valid;
  logic                      pix_stall;
  logic                      func;
  logic [7:0]                red;
  logic [7:0]                green;
  logic [7:0]                blue;
  logic                      end_of_row;
  logic                      end_of_frame;
  logic                      res_valid;
  logic                      res_stall;
  logic signed [SHIFT_W-1:0] best_shift;
  logic [SUM_OUT_W-1:0]      best_sum;
  logic [ROWS_OUT_W-1:0]     best_rows;

  int fails;
  int pending;
  int quiet_cycles = 0;
  int pixel_count = 0;
  int ref_frames = 0;
  int smp_frames = 0;
  int settings_count = 1;
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;
  bit ref_seen [ROW_STORE];
  bit smp_seen [ROW_STORE];

  row_projection_shift_estimator i_dut (.*);

  shift_estimate_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        res_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        res_stall <= 1'b0;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input bit f, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input bit eor, input bit eof);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      pix_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    pix_valid <= 1'b1;
    func <= f;
    red <= r;
    green <= g;
    blue <= b;
    end_of_row <= eor;
    end_of_frame <= eof;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    pixel_count++;
  endtask

  task automatic send_frame(input bit kind, input int rows, input int min_cols,
                            input int max_cols, input bit bright);
    int         y, c, cols, idx;
    bit         last_f, last_eor;
    logic [7:0] r, g, b;
    idx = 0;
    for (y = 0; y < rows; y++) begin
      cols = $urandom_range(min_cols, max_cols);
      for (c = 0; c < cols; c++) begin
        r = bright ? 8'hFF : pick_level();
        g = bright ? 8'hFF : pick_level();
        b = bright ? 8'hFF : pick_level();
        if (c < cols - 1) begin
          send_pixel(1'($urandom_range(0, 1)), r, g, b, 1'b0, 1'b0);
        end else begin
          last_f = kind;
          // divert a row only where this frame's store already holds that row
          if (y < rows - 1 && idx < ROW_STORE && $urandom_range(0, 7) == 0 &&
              (kind ? smp_seen[idx] : ref_seen[idx])) begin
            last_f = !kind;
          end
          last_eor = (y < rows - 1) ? 1'b1 : 1'($urandom_range(0, 1));
          send_pixel(last_f, r, g, b, last_eor, y == rows - 1);
          if (idx < ROW_STORE) begin
            if (last_f) smp_seen[idx] = 1'b1;
            else ref_seen[idx] = 1'b1;
            idx++;
          end
        end
      end
    end
    if (kind) smp_frames++;
    else ref_frames++;
  endtask

  task automatic settle();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_range(input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SEARCH_RANGE;
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // read back through a fresh setup cycle
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    settings_count++;
  endtask

  task automatic random_phase(input int span, input bit pressure, input bit quiet);
    int start;
    bit kind;
    settle();
    program_range(span);
    if (pressure) hold_req = 1'b1;
    start = pixel_count;
    kind = 1'b0;
    while (pixel_count - start < PHASE_PIXELS) begin
      tx_idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
      rx_idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
      send_frame(kind, ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12),
                 1, $urandom_range(1, 8), 1'b0);
      kind = 1'($urandom_range(0, 1));
    end
  endtask

  initial begin : stimulus
    int i;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pix_valid <= 1'b0;
    func <= 1'b0;
    red <= '0;
    green <= '0;
    blue <= '0;
    end_of_row <= 1'b0;
    end_of_frame <= 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // sample frame before any reference: no overlap; frame end without row end
    send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1);
    // reference frame with extreme colors and a stray sample func mid-row
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    send_pixel(1'b0, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b0);
    send_pixel(1'b0, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0);
    send_pixel(1'b0, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1);
    // sample frame whose first row lands in the reference store
    send_pixel(1'b1, 8'd10, 8'd20, 8'd30, 1'b0, 1'b0);
    send_pixel(1'b0, 8'd200, 8'd100, 8'd50, 1'b1, 1'b0);
    send_pixel(1'b1, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0);
    send_pixel(1'b1, 8'd128, 8'd128, 8'd128, 1'b1, 1'b1);
    // identical flat frames: every overlapping shift ties, the most negative must win
    send_pixel(1'b0, 8'd100, 8'd100, 8'd100, 1'b1, 1'b0);
    send_pixel(1'b0, 8'd100, 8'd100, 8'd100, 1'b1, 1'b0);
    send_pixel(1'b0, 8'd100, 8'd100, 8'd100, 1'b1, 1'b1);
    send_pixel(1'b1, 8'd100, 8'd100, 8'd100, 1'b1, 1'b0);
    send_pixel(1'b1, 8'd100, 8'd100, 8'd100, 1'b1, 1'b0);
    send_pixel(1'b1, 8'd100, 8'd100, 8'd100, 1'b1, 1'b1);
    for (i = 0; i < 3; i++) begin
      ref_seen[i] = 1'b1;
      smp_seen[i] = 1'b1;
    end
    ref_frames += 2;
    smp_frames += 3;

    // frames taller than the row store, then a row wide enough to saturate
    settle();
    program_range(2);
    send_frame(1'b0, ROW_STORE + 6, 1, 1, 1'b0);
    send_frame(1'b1, ROW_STORE + 6, 1, 1, 1'b0);
    send_frame(1'b1, 1, 1100, 1100, 1'b1);

    random_phase(0, 1'b0, 1'b0);
    random_phase(1023, 1'b0, 1'b0);
    random_phase(1, 1'b0, 1'b0);
    random_phase(160, 1'b1, 1'b0);
    random_phase($urandom_range(2, 1022), 1'b0, 1'b0);
    random_phase(5, 1'b0, 1'b1);
    settle();

    $display("Run covered %0d pixels in %0d reference and %0d sample frames over %0d range settings.",
             pixel_count, ref_frames, smp_frames, settings_count);
    $display("Included tall frames, a saturated row, diverted rows, ties and a long result hold-off.");
    if (fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results still pending", fails, pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rpse_pkg.sv
hdl/rpse_ram.sv
hdl/rpse_front.sv
hdl/rpse_search.sv
hdl/row_projection_shift_estimator.sv
hdl/rpse_checker.sv
tb/shift_estimate_checker.sv
tb/tb_top.sv
